// ===== rtl/gmr_pkg.sv =====
// shared constants, codes and command/status types of the grid maze reachability block
package gmr_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int MAX_COLS   = 32;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int DIM_W      = 6;
  localparam int POS_W      = $clog2(CELLS);
  localparam int CNT_W      = POS_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 3'd0,
    CFG_COL_COUNT = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_GOAL_ROW  = 3'd4,
    CFG_GOAL_COL  = 3'd5
  } gmr_cfg_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } gmr_dir_e;

  typedef struct packed {
    logic     load;
    logic     init;
    logic     mark;
    logic     push;
    logic     pop;
    logic     take;
    logic     nb_calc;
    gmr_dir_e dir;
    logic     emit;
    logic     emit_val;
  } gmr_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic trivial_hit;
    logic off_grid;
    logic stack_empty;
    logic nb_ok;
    logic nb_enter;
    logic nb_goal;
  } gmr_sts_t;

endpackage

// ===== rtl/gmr_if.sv =====
// valid/ready channel interfaces for maze cells and results
interface gmr_in_if;
  logic valid;
  logic ready;
  logic cell_open;
  logic last_cell;

  modport source (output valid, output cell_open, output last_cell, input ready);
  modport sink (input valid, input cell_open, input last_cell, output ready);
  modport monitor (input valid, input cell_open, input last_cell, input ready);
endinterface

interface gmr_out_if;
  logic valid;
  logic ready;
  logic path_found;

  modport source (output valid, output path_found, input ready);
  modport sink (input valid, input path_found, output ready);
  modport monitor (input valid, input path_found, input ready);
endinterface

// ===== rtl/gmr_ram.sv =====
// generic simple dual-port ram with registered read
module gmr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gmr_ctrl.sv =====
// search sequencer: cell loading, stack walk and result hand-off
module gmr_ctrl
  import gmr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  gmr_sts_t sts_i,
  output gmr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_INIT,
    ST_START_PUSH,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_CALC,
    ST_NB_READ,
    ST_NB_CHECK,
    ST_REPORT
  } state_e;

  state_e   state_q;
  gmr_dir_e dir_q;
  logic     found_q;
  gmr_dir_e dir_next;

  always_comb begin
    case (dir_q)
      DIR_N:   dir_next = DIR_S;
      DIR_S:   dir_next = DIR_W;
      DIR_W:   dir_next = DIR_E;
      default: dir_next = DIR_N;
    endcase
  end

  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    cmd_o          = '0;
    cmd_o.dir      = dir_q;
    cmd_o.emit_val = found_q;
    case (state_q)
      ST_LOAD:       cmd_o.load = in_valid_i;
      ST_INIT:       cmd_o.init = 1'b1;
      ST_START_PUSH: begin
        cmd_o.mark = 1'b1;
        cmd_o.push = 1'b1;
      end
      ST_POP:        cmd_o.pop = !sts_i.stack_empty;
      ST_POP_WAIT:   cmd_o.take = 1'b1;
      ST_NB_CALC:    cmd_o.nb_calc = sts_i.nb_ok;
      ST_NB_CHECK:   begin
        cmd_o.mark = sts_i.nb_enter;
        cmd_o.push = sts_i.nb_enter && !sts_i.nb_goal;
      end
      ST_REPORT:     cmd_o.emit = !sts_i.out_busy;
      default:       cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      dir_q   <= DIR_N;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i && in_last_i) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (sts_i.trivial_hit) begin
            found_q <= 1'b1;
            state_q <= ST_REPORT;
          end else if (sts_i.off_grid) begin
            found_q <= 1'b0;
            state_q <= ST_REPORT;
          end else begin
            state_q <= ST_INIT;
          end
        end
        ST_INIT:       state_q <= ST_START_PUSH;
        ST_START_PUSH: state_q <= ST_POP;
        ST_POP: begin
          if (sts_i.stack_empty) begin
            found_q <= 1'b0;
            state_q <= ST_REPORT;
          end else begin
            state_q <= ST_POP_WAIT;
          end
        end
        ST_POP_WAIT: begin
          dir_q   <= DIR_N;
          state_q <= ST_NB_CALC;
        end
        ST_NB_CALC: begin
          if (sts_i.nb_ok) begin
            state_q <= ST_NB_READ;
          end else if (dir_q == DIR_E) begin
            state_q <= ST_POP;
          end else begin
            dir_q <= dir_next;
          end
        end
        ST_NB_READ: state_q <= ST_NB_CHECK;
        ST_NB_CHECK: begin
          if (sts_i.nb_enter && sts_i.nb_goal) begin
            found_q <= 1'b1;
            state_q <= ST_REPORT;
          end else if (dir_q == DIR_E) begin
            state_q <= ST_POP;
          end else begin
            dir_q   <= dir_next;
            state_q <= ST_NB_CALC;
          end
        end
        ST_REPORT: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/gmr_dp.sv =====
// datapath: configuration, cell/visited/stack memories, neighbour address and result register
module gmr_dp
  import gmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cell_open_i,
  input  gmr_cmd_t              cmd_i,
  output gmr_sts_t              sts_o,
  input  logic                  res_ready_i,
  output logic                  res_valid_o,
  output logic                  path_found_o
);

  logic [DIM_W-1:0] row_count_q, col_count_q;
  logic [ROW_W-1:0] start_row_q, goal_row_q;
  logic [COL_W-1:0] start_col_q, goal_col_q;
  logic [DIM_W-1:0] rows, cols;

  logic [CNT_W-1:0] load_idx_q, depth_q, depth_dec;
  logic             load_room, stack_room;

  logic [ROW_W-1:0] cur_r_q, nb_r, mul_r, nb_r_q;
  logic [COL_W-1:0] cur_c_q, nb_c, mul_c, nb_c_q;
  logic             nb_ok;
  logic [ROW_W+DIM_W-1:0] pos_sum;
  logic [POS_W-1:0] nb_pos_q;
  logic             nb_goal_q;

  logic             open_rd, vis_rd;
  logic             vis_we, vis_wdata;
  logic [POS_W-1:0] vis_waddr;
  logic [ROW_W+COL_W-1:0] stk_rdata;

  logic res_valid_q, res_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DIM_W'(MAX_ROWS);
      col_count_q <= DIM_W'(MAX_COLS);
      start_row_q <= '0;
      start_col_q <= '0;
      goal_row_q  <= '0;
      goal_col_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT: row_count_q <= cfg_data_i[DIM_W-1:0];
        CFG_COL_COUNT: col_count_q <= cfg_data_i[DIM_W-1:0];
        CFG_START_ROW: start_row_q <= cfg_data_i[ROW_W-1:0];
        CFG_START_COL: start_col_q <= cfg_data_i[COL_W-1:0];
        CFG_GOAL_ROW:  goal_row_q  <= cfg_data_i[ROW_W-1:0];
        CFG_GOAL_COL:  goal_col_q  <= cfg_data_i[COL_W-1:0];
        default:       start_row_q <= start_row_q;
      endcase
    end
  end

  // saturate grid size into the supported range
  always_comb begin
    rows = row_count_q;
    if (row_count_q == '0) begin
      rows = DIM_W'(1);
    end else if (row_count_q > DIM_W'(MAX_ROWS)) begin
      rows = DIM_W'(MAX_ROWS);
    end
    cols = col_count_q;
    if (col_count_q == '0) begin
      cols = DIM_W'(1);
    end else if (col_count_q > DIM_W'(MAX_COLS)) begin
      cols = DIM_W'(MAX_COLS);
    end
  end

  // neighbour coordinates for the current direction
  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_ok = 1'b0;
    case (cmd_i.dir)
      DIR_N: begin
        nb_ok = (cur_r_q != '0);
        nb_r  = cur_r_q - ROW_W'(1);
      end
      DIR_S: begin
        nb_ok = ((DIM_W'(cur_r_q) + DIM_W'(1)) < rows);
        nb_r  = cur_r_q + ROW_W'(1);
      end
      DIR_W: begin
        nb_ok = (cur_c_q != '0);
        nb_c  = cur_c_q - COL_W'(1);
      end
      DIR_E: begin
        nb_ok = ((DIM_W'(cur_c_q) + DIM_W'(1)) < cols);
        nb_c  = cur_c_q + COL_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign mul_r   = cmd_i.init ? start_row_q : nb_r;
  assign mul_c   = cmd_i.init ? start_col_q : nb_c;
  assign pos_sum = (ROW_W+DIM_W)'(mul_r) * (ROW_W+DIM_W)'(cols) + (ROW_W+DIM_W)'(mul_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.nb_calc) begin
      nb_r_q    <= mul_r;
      nb_c_q    <= mul_c;
      nb_pos_q  <= pos_sum[POS_W-1:0];
      nb_goal_q <= (mul_r == goal_row_q) && (mul_c == goal_col_q);
    end
    if (cmd_i.take) begin
      cur_r_q <= stk_rdata[ROW_W+COL_W-1:COL_W];
      cur_c_q <= stk_rdata[COL_W-1:0];
    end
  end

  assign load_room  = (load_idx_q < CNT_W'(CELLS));
  assign stack_room = (depth_q < CNT_W'(CELLS));
  assign depth_dec  = depth_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q  <= '0;
      depth_q     <= '0;
      res_valid_q <= 1'b0;
      res_val_q   <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        load_idx_q <= '0;
      end else if (cmd_i.load && load_room) begin
        load_idx_q <= load_idx_q + CNT_W'(1);
      end
      if (cmd_i.init) begin
        depth_q <= '0;
      end else if (cmd_i.push && stack_room) begin
        depth_q <= depth_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_dec;
      end
      if (cmd_i.emit) begin
        res_valid_q <= 1'b1;
        res_val_q   <= cmd_i.emit_val;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  gmr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && load_room),
    .waddr_i (load_idx_q[POS_W-1:0]),
    .wdata_i (cell_open_i),
    .raddr_i (nb_pos_q),
    .rdata_o (open_rd)
  );

  // loading a cell also clears its visit mark
  assign vis_we    = (cmd_i.load && load_room) || cmd_i.mark;
  assign vis_waddr = cmd_i.mark ? nb_pos_q : load_idx_q[POS_W-1:0];
  assign vis_wdata = cmd_i.mark;

  gmr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (nb_pos_q),
    .rdata_o (vis_rd)
  );

  gmr_ram #(.WIDTH(ROW_W+COL_W), .DEPTH(CELLS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && stack_room),
    .waddr_i (depth_q[POS_W-1:0]),
    .wdata_i ({nb_r_q, nb_c_q}),
    .raddr_i (depth_dec[POS_W-1:0]),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    sts_o             = '0;
    sts_o.out_busy    = res_valid_q && !res_ready_i;
    sts_o.trivial_hit = (start_row_q == goal_row_q) && (start_col_q == goal_col_q);
    sts_o.off_grid    = (DIM_W'(start_row_q) >= rows) || (DIM_W'(start_col_q) >= cols) ||
                        (DIM_W'(goal_row_q) >= rows) || (DIM_W'(goal_col_q) >= cols);
    sts_o.stack_empty = (depth_q == '0);
    sts_o.nb_ok       = nb_ok;
    sts_o.nb_enter    = open_rd && !vis_rd && (CNT_W'(nb_pos_q) < load_idx_q);
    sts_o.nb_goal     = nb_goal_q;
  end

  assign res_valid_o  = res_valid_q;
  assign path_found_o = res_val_q;

endmodule

// ===== rtl/grid_maze_reachability.sv =====
// grid maze reachability top level: channel interfaces, configuration port, controller and datapath
// Cells are taken one per cycle in row-major order while the block is loading. The cell
// flagged last_cell closes the maze and starts a depth-first walk from the start cell;
// input ready stays low until the walk ends and its one-bit result has been placed in the
// output register. The walk is driven by a single sequencer sharing one neighbour address
// multiplier and the cell, visit and stack memories: each popped cell passes through a pop
// and a pop-wait state, each in-grid neighbour through address, read and check states, and
// each side on the grid edge through the address state alone; setup and hand-off states
// lie around the walk. The next maze may be loaded while a result waits to be taken.
// Visit marks are cleared as cells load, so no clearing pass is needed after reset.
module grid_maze_reachability
  import gmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gmr_in_if.sink                cell_i,
  gmr_out_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  gmr_cmd_t cmd;
  gmr_sts_t sts;
  logic     in_ready;
  logic     res_valid;
  logic     path_found;

  gmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cell_i.valid),
    .in_last_i  (cell_i.last_cell),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gmr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_open_i  (cell_i.cell_open),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_valid),
    .path_found_o (path_found)
  );

  assign cell_i.ready     = in_ready;
  assign res_o.valid      = res_valid;
  assign res_o.path_found = path_found;

endmodule

// ===== rtl/gmr_checker.sv =====
// port-level checks of the grid maze reachability block and their binding
module gmr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic res_valid_i,
  input logic res_ready_i
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // the closing cell starts the walk, so input is held off next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken while the walk runs");

  // a fresh result always comes with the block back in loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> in_ready_i)
    else $error("result raised while still searching");

  // no result is produced without a preceding closing cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(in_ready_i))
    else $error("result without a finished maze");

endmodule

bind grid_maze_reachability gmr_checker u_gmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_i.valid),
  .in_ready_i  (cell_i.ready),
  .in_last_i   (cell_i.last_cell),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the grid maze reachability block: maze stimulus, path prediction and checks
module testbench;
  import gmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 450;
  localparam int FROM_PREDICTOR = -1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    PAT_OPEN, PAT_WALL, PAT_SCATTER, PAT_SNAKE, PAT_DIVIDE, PAT_NO_GOAL, PAT_NO_START
  } pattern_e;

  typedef struct packed {
    bit          setup;
    logic [5:0]  rows;
    logic [5:0]  cols;
    logic [4:0]  srow;
    logic [4:0]  scol;
    logic [4:0]  grow;
    logic [4:0]  gcol;
    pattern_e    kind;
    int          count;
    int          verdict;
  } maze_case_t;

  // count 0 loads the whole grid
  localparam maze_case_t PLAN [23] = '{
    '{1'b0, 6'd32, 6'd32, 5'd0,  5'd0,  5'd0,  5'd0,  PAT_OPEN,     1,    1},
    '{1'b1, 6'd1,  6'd1,  5'd0,  5'd0,  5'd0,  5'd0,  PAT_WALL,     0,    1},
    '{1'b1, 6'd1,  6'd2,  5'd0,  5'd0,  5'd0,  5'd1,  PAT_OPEN,     0,    FROM_PREDICTOR},
    '{1'b1, 6'd1,  6'd2,  5'd0,  5'd0,  5'd0,  5'd1,  PAT_NO_GOAL,  0,    0},
    '{1'b1, 6'd2,  6'd2,  5'd0,  5'd0,  5'd1,  5'd1,  PAT_WALL,     0,    0},
    '{1'b1, 6'd3,  6'd3,  5'd1,  5'd1,  5'd0,  5'd0,  PAT_NO_START, 0,    FROM_PREDICTOR},
    '{1'b1, 6'd0,  6'd4,  5'd0,  5'd0,  5'd0,  5'd3,  PAT_OPEN,     0,    FROM_PREDICTOR},
    '{1'b1, 6'd63, 6'd1,  5'd0,  5'd0,  5'd31, 5'd0,  PAT_OPEN,     0,    FROM_PREDICTOR},
    '{1'b1, 6'd3,  6'd0,  5'd0,  5'd0,  5'd2,  5'd0,  PAT_OPEN,     0,    FROM_PREDICTOR},
    '{1'b1, 6'd1,  6'd40, 5'd0,  5'd31, 5'd0,  5'd0,  PAT_OPEN,     0,    FROM_PREDICTOR},
    '{1'b1, 6'd4,  6'd4,  5'd5,  5'd0,  5'd0,  5'd0,  PAT_OPEN,     0,    0},
    '{1'b1, 6'd4,  6'd4,  5'd0,  5'd0,  5'd0,  5'd31, PAT_OPEN,     0,    0},
    '{1'b1, 6'd2,  6'd2,  5'd31, 5'd31, 5'd31, 5'd31, PAT_WALL,     0,    1},
    '{1'b1, 6'd3,  6'd3,  5'd0,  5'd0,  5'd2,  5'd2,  PAT_OPEN,     5,    FROM_PREDICTOR},
    '{1'b1, 6'd3,  6'd3,  5'd0,  5'd0,  5'd1,  5'd1,  PAT_OPEN,     5,    FROM_PREDICTOR},
    '{1'b1, 6'd5,  6'd5,  5'd0,  5'd0,  5'd4,  5'd4,  PAT_DIVIDE,   0,    FROM_PREDICTOR},
    '{1'b1, 6'd8,  6'd8,  5'd0,  5'd0,  5'd7,  5'd0,  PAT_SNAKE,    0,    FROM_PREDICTOR},
    '{1'b1, 6'd32, 6'd32, 5'd0,  5'd0,  5'd31, 5'd31, PAT_OPEN,     1030, FROM_PREDICTOR},
    '{1'b1, 6'd10, 6'd10, 5'd0,  5'd0,  5'd8,  5'd0,  PAT_SNAKE,    0,    FROM_PREDICTOR},
    '{1'b1, 6'd6,  6'd6,  5'd5,  5'd5,  5'd0,  5'd0,  PAT_SCATTER,  0,    FROM_PREDICTOR},
    '{1'b1, 6'd32, 6'd32, 5'd31, 5'd31, 5'd31, 5'd30, PAT_WALL,     1,    0},
    '{1'b1, 6'd6,  6'd7,  5'd2,  5'd3,  5'd5,  5'd0,  PAT_SCATTER,  0,    FROM_PREDICTOR},
    '{1'b0, 6'd6,  6'd7,  5'd2,  5'd3,  5'd5,  5'd0,  PAT_SCATTER,  0,    FROM_PREDICTOR}
  };

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  sink_rdy   = 1'b0;
  int                    sink_hold  = 0;

  gmr_in_if  cell_ch ();
  gmr_out_if res_ch ();

  assign res_ch.ready = sink_rdy;

  grid_maze_reachability DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the registers and the maze
  logic [5:0]  rows_cfg = 6'd32;
  logic [5:0]  cols_cfg = 6'd32;
  logic [4:0]  srow_cfg = '0;
  logic [4:0]  scol_cfg = '0;
  logic [4:0]  grow_cfg = '0;
  logic [4:0]  gcol_cfg = '0;
  bit          open_cells [CELLS];
  bit          seen [CELLS];
  int unsigned trail [CELLS];
  int unsigned trail_len = 0;
  int unsigned loaded    = 0;

  bit reach_q [$];
  int fixed_q [$];

  int  density       = 60;
  int  error_count   = 0;
  int  mazes_sent    = 0;
  int  results_seen  = 0;
  int  found_count   = 0;
  int  cells_taken   = 0;
  int  setting_count = 0;
  int  quiet         = 0;
  bit  predicted;
  bit  want;
  int  fixed_val;

  function automatic int unsigned span(logic [5:0] v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit step_into(int unsigned p, int unsigned goal_p);
    if (p >= CELLS || seen[p] || !(p < loaded && open_cells[p])) return 1'b0;
    seen[p] = 1'b1;
    if (p == goal_p) return 1'b1;
    if (trail_len < CELLS) begin
      trail[trail_len] = p;
      trail_len++;
    end
    return 1'b0;
  endfunction

  function automatic bit walk_maze();
    int unsigned nr, nc, gp, p, r, c;
    nr = span(rows_cfg, MAX_ROWS);
    nc = span(cols_cfg, MAX_COLS);
    if (srow_cfg == grow_cfg && scol_cfg == gcol_cfg) return 1'b1;
    if (srow_cfg >= nr || scol_cfg >= nc) return 1'b0;
    if (grow_cfg >= nr || gcol_cfg >= nc) return 1'b0;
    gp = grow_cfg * nc + gcol_cfg;
    foreach (seen[i]) seen[i] = 1'b0;
    p = srow_cfg * nc + scol_cfg;
    seen[p] = 1'b1;
    trail[0] = p;
    trail_len = 1;
    while (trail_len > 0) begin
      trail_len--;
      p = trail[trail_len];
      r = p / nc;
      c = p % nc;
      if (r > 0 && step_into(p - nc, gp)) return 1'b1;
      if (r + 1 < nr && step_into(p + nc, gp)) return 1'b1;
      if (c > 0 && step_into(p - 1, gp)) return 1'b1;
      if (c + 1 < nc && step_into(p + 1, gp)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic cell_at(pattern_e kind, int unsigned pos, nr, nc, sp, gp);
    int unsigned r, c;
    if (pos >= nr * nc) return $urandom_range(0, 1) != 0;
    r = pos / nc;
    c = pos % nc;
    case (kind)
      PAT_OPEN:     return 1'b1;
      PAT_WALL:     return 1'b0;
      PAT_SNAKE:    return (r % 2 == 0) || ((r % 4 == 1) ? (c == nc - 1) : (c == 0));
      PAT_DIVIDE:   return (nc > 1) ? (c != nc / 2) : (r != nr / 2);
      PAT_NO_GOAL:  return pos != gp;
      PAT_NO_START: return pos != sp;
      default:      return $urandom_range(0, 99) < density;
    endcase
  endfunction

  task automatic send_cell(logic open_bit, logic last_bit, bit eager);
    int gap;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_ch.valid     <= 1'b1;
    cell_ch.cell_open <= open_bit;
    cell_ch.last_cell <= last_bit;
    do @(posedge clk_i); while (!cell_ch.ready);
  endtask

  task automatic send_maze(pattern_e kind, int count, bit eager, output int sent);
    int unsigned nr, nc, sp, gp, total;
    nr = span(rows_cfg, MAX_ROWS);
    nc = span(cols_cfg, MAX_COLS);
    sp = srow_cfg * nc + scol_cfg;
    gp = grow_cfg * nc + gcol_cfg;
    total = (count == 0) ? nr * nc : count;
    for (int unsigned i = 0; i < total; i++) begin
      send_cell(cell_at(kind, i, nr, nc, sp, gp), i == total - 1, eager);
    end
    mazes_sent++;
    sent = total;
  endtask

  task automatic settle();
    cell_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen != mazes_sent);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_COUNT: rows_cfg = data;
      CFG_COL_COUNT: cols_cfg = data;
      CFG_START_ROW: srow_cfg = data[4:0];
      CFG_START_COL: scol_cfg = data[4:0];
      CFG_GOAL_ROW:  grow_cfg = data[4:0];
      CFG_GOAL_COL:  gcol_cfg = data[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [5:0] nr, nc, sr, sc, gr, gc, bit spare);
    write_reg(CFG_ROW_COUNT, nr);
    write_reg(CFG_COL_COUNT, nc);
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_GOAL_ROW, gr);
    write_reg(CFG_GOAL_COL, gc);
    if (spare) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 6'($urandom_range(0, 63)));
    end
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [5:0] pick_dim(bit wide);
    if (wide) return 6'($urandom_range(9, 63));
    if ($urandom_range(0, 15) == 0) return 6'd0;
    return 6'($urandom_range(1, 8));
  endfunction

  // mostly inside the grid, sometimes anywhere, with the spare top bit now and then
  function automatic logic [5:0] pick_coord(int unsigned lim);
    logic [5:0] v;
    v[4:0] = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, lim - 1))
                                          : 5'($urandom_range(0, 31));
    v[5] = ($urandom_range(0, 15) == 0);
    return v;
  endfunction

  task automatic shuffle_setup();
    logic [5:0] nr, nc, sr, sc, gr, gc;
    int pick;
    pick = $urandom_range(0, 7);
    nr = pick_dim(pick == 0);
    nc = pick_dim(pick == 1);
    sr = pick_coord(span(nr, MAX_ROWS));
    sc = pick_coord(span(nc, MAX_COLS));
    gr = pick_coord(span(nr, MAX_ROWS));
    gc = pick_coord(span(nc, MAX_COLS));
    if ($urandom_range(0, 15) == 0) begin
      gr = sr;
      gc = sc;
    end
    configure(nr, nc, sr, sc, gr, gc, $urandom_range(0, 9) == 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cell_ch.valid && cell_ch.ready) begin
      cells_taken++;
      if (loaded < CELLS) begin
        open_cells[loaded] = cell_ch.cell_open;
        loaded++;
      end
      if (cell_ch.last_cell) begin
        predicted = walk_maze();
        fixed_val = (fixed_q.size() != 0) ? fixed_q.pop_front() : FROM_PREDICTOR;
        if (fixed_val != FROM_PREDICTOR) predicted = (fixed_val != 0);
        reach_q.push_back(predicted);
        loaded = 0;
      end
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (reach_q.size() == 0) begin
        $error("path_found: unexpected transaction, expected none, actual %0d",
               res_ch.path_found);
        error_count++;
      end else begin
        want = reach_q.pop_front();
        if (res_ch.path_found !== want) begin
          $error("path_found mismatch: expected %0d, actual %0d", want, res_ch.path_found);
          error_count++;
        end
      end
      results_seen++;
      if (res_ch.path_found === 1'b1) found_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_rdy  <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      sink_rdy  <= 1'b1;
      sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 12);
    end else begin
      sink_rdy  <= 1'b0;
      sink_hold <= pick_gap();
    end
  end

  initial begin
    int       sent;
    int       random_items;
    int       roll;
    int       count;
    int       cells;
    bit       eager;
    bit       first;
    pattern_e kind;

    cell_ch.valid     = 1'b0;
    cell_ch.cell_open = 1'b0;
    cell_ch.last_cell = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].setup) begin
        settle();
        configure(PLAN[i].rows, PLAN[i].cols, {1'b0, PLAN[i].srow}, {1'b0, PLAN[i].scol},
                  {1'b0, PLAN[i].grow}, {1'b0, PLAN[i].gcol}, 1'b0);
      end
      fixed_q.push_back(PLAN[i].verdict);
      send_maze(PLAN[i].kind, PLAN[i].count, 1'b0, sent);
    end

    random_items = 0;
    first = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 3) == 0) begin
        settle();
        shuffle_setup();
        first = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70)      kind = PAT_SCATTER;
      else if (roll < 78) kind = PAT_SNAKE;
      else if (roll < 84) kind = PAT_DIVIDE;
      else if (roll < 88) kind = PAT_OPEN;
      else if (roll < 92) kind = PAT_NO_GOAL;
      else if (roll < 95) kind = PAT_NO_START;
      else                kind = PAT_WALL;
      density = $urandom_range(45, 85);
      cells = span(rows_cfg, MAX_ROWS) * span(cols_cfg, MAX_COLS);
      roll = $urandom_range(0, 99);
      if (roll < 86)      count = 0;
      else if (roll < 95) count = $urandom_range(1, cells);
      else                count = cells + $urandom_range(1, 6);
      eager = ($urandom_range(0, 4) == 0);
      fixed_q.push_back(FROM_PREDICTOR);
      send_maze(kind, count, eager, sent);
      random_items += sent;
    end

    settle();
    $display("covered %0d mazes under %0d register settings, %0d cells accepted",
             mazes_sent, setting_count, cells_taken);
    $display("%0d path results checked, %0d of them reachable", results_seen, found_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
